// ----- design/pls_pkg.sv -----
// Package for the positional list store: sizes, operation and status codes,
// and the controller command type. No dependencies.
`default_nettype none

package pls_pkg;

  // Store depth and derived widths
  localparam int Capacity = 16;
  localparam int IdxW     = $clog2(Capacity);
  localparam int CntW     = 5;   // entry_count / position field width
  localparam int ValW     = 32;

  localparam logic [CntW-1:0] CapacityCnt = CntW'(Capacity);

  // Operation kind, carried in tuser
  typedef enum logic [1:0] {
    KIND_INSERT   = 2'd0,
    KIND_APPEND   = 2'd1,
    KIND_REMOVE   = 2'd2,
    KIND_RETRIEVE = 2'd3
  } kind_e;

  // Result status
  typedef enum logic [1:0] {
    STAT_DONE  = 2'd0,
    STAT_FULL  = 2'd1,
    STAT_RANGE = 2'd2
  } status_e;

  // Controller to datapath command
  typedef struct packed {
    logic exec;     // perform the accepted operation, load the result word
    logic hold;     // a result word is waiting at the output
  } cmd_t;

endpackage

`default_nettype wire

// ----- design/positional_list_store.sv -----
// A word accepted at one edge shows its registered result at m_tvalid in the next cycle.
// One word per cycle while the output slot is free or draining; every entry cell shifts in parallel.
// A result waiting at the output that is not taken holds s_tready low until it drains.
// Reset: entry count cleared, output slot empty; entry contents stay undefined.
// Top level of the positional list store: controller plus datapath.
// Depends on pls_pkg, pls_ctrl and pls_datapath.
`default_nettype none

module positional_list_store (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        s_tvalid,
  output logic             s_tready,
  input  wire logic [39:0] s_tdata,   // position[4:0], item_value[36:5], zero pad
  input  wire logic [1:0]  s_tuser,   // kind[1:0]
  output logic             m_tvalid,
  input  wire logic        m_tready,
  output logic [39:0]      m_tdata    // status[1:0], read_value[33:2],
                                      // entry_count[38:34], is_empty[39]
);
  import pls_pkg::*;

  cmd_t                   cmd;
  status_e                status;
  logic signed [ValW-1:0] read_value;
  logic [CntW-1:0]        entry_count;
  logic                   is_empty;

  pls_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_tvalid),
    .in_ready_o  (s_tready),
    .out_valid_o (m_tvalid),
    .out_ready_i (m_tready),
    .cmd_o       (cmd)
  );

  pls_datapath u_dp (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_i         (cmd),
    .kind_i        (s_tuser),
    .position_i    (s_tdata[4:0]),
    .item_value_i  ($signed(s_tdata[36:5])),
    .status_o      (status),
    .read_value_o  (read_value),
    .entry_count_o (entry_count),
    .is_empty_o    (is_empty)
  );

  assign m_tdata = {is_empty, entry_count, read_value, status};

endmodule

`default_nettype wire

// ----- design/pls_ctrl.sv -----
// Controller of the positional list store: input/output handshake state.
// Depends on pls_pkg.
`default_nettype none

module pls_ctrl (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        in_valid_i,
  output logic             in_ready_o,
  output logic             out_valid_o,
  input  wire logic        out_ready_i,
  output pls_pkg::cmd_t    cmd_o
);
  import pls_pkg::*;

  localparam logic ST_IDLE = 1'b0;
  localparam logic ST_HOLD = 1'b1;

  logic state_q, state_d;
  logic exec;

  // A new word may enter whenever the output slot is free or being drained
  assign in_ready_o  = (state_q == ST_IDLE) || out_ready_i;
  assign out_valid_o = (state_q == ST_HOLD);
  assign exec        = in_valid_i && in_ready_o;

  always_comb begin
    unique case (state_q)
      ST_IDLE: state_d = exec ? ST_HOLD : ST_IDLE;
      ST_HOLD: begin
        if (exec) state_d = ST_HOLD;
        else if (out_ready_i) state_d = ST_IDLE;
        else state_d = ST_HOLD;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  assign cmd_o.exec = exec;
  assign cmd_o.hold = out_valid_o;

endmodule

`default_nettype wire

// ----- design/pls_datapath.sv -----
// Datapath of the positional list store: the chain of entry cells, the
// entry count and the result register. Depends on pls_pkg.
`default_nettype none

module pls_datapath (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire pls_pkg::cmd_t                 cmd_i,
  input  wire logic [1:0]                    kind_i,
  input  wire logic [pls_pkg::CntW-1:0]      position_i,
  input  wire logic signed [pls_pkg::ValW-1:0] item_value_i,
  output pls_pkg::status_e                   status_o,
  output logic signed [pls_pkg::ValW-1:0]    read_value_o,
  output logic [pls_pkg::CntW-1:0]           entry_count_o,
  output logic                               is_empty_o
);
  import pls_pkg::*;

  logic signed [ValW-1:0] cells_q [Capacity];
  logic signed [ValW-1:0] cells_d [Capacity];
  logic [CntW-1:0]        count_q, count_d;

  status_e                status_q, status_d;
  logic signed [ValW-1:0] rdval_q, rdval_d;
  logic [CntW-1:0]        rcount_q;

  kind_e           kind;
  logic [CntW-1:0] ins_pos;
  logic            is_full;
  logic            do_ins, do_rem;

  assign kind    = kind_e'(kind_i);
  assign is_full = (count_q == CapacityCnt);
  assign ins_pos = (kind == KIND_APPEND) ? count_q : position_i;

  // Decode the operation into status, read value and shift enables
  always_comb begin
    status_d = STAT_DONE;
    rdval_d  = '0;
    do_ins   = 1'b0;
    do_rem   = 1'b0;
    unique case (kind)
      KIND_INSERT, KIND_APPEND: begin
        if (is_full) status_d = STAT_FULL;
        else if (ins_pos > count_q) status_d = STAT_RANGE;
        else do_ins = 1'b1;
      end
      KIND_REMOVE: begin
        if (position_i >= count_q) status_d = STAT_RANGE;
        else do_rem = 1'b1;
      end
      KIND_RETRIEVE: begin
        if (position_i < count_q) rdval_d = cells_q[position_i[IdxW-1:0]];
        else status_d = STAT_RANGE;
      end
      default: status_d = STAT_RANGE;
    endcase
  end

  // Each cell takes its lower neighbor on insert, its upper one on remove
  always_comb begin
    for (int m = 0; m < Capacity; m++) begin
      cells_d[m] = cells_q[m];
      if (do_ins) begin
        if (CntW'(m) == ins_pos) cells_d[m] = item_value_i;
        else if (m > 0 && CntW'(m) > ins_pos) cells_d[m] = cells_q[(m > 0) ? m - 1 : 0];
      end else if (do_rem) begin
        if (m < Capacity - 1 && CntW'(m) >= position_i)
          cells_d[m] = cells_q[(m < Capacity - 1) ? m + 1 : m];
      end
    end
  end

  always_comb begin
    count_d = count_q;
    if (do_ins) count_d = count_q + CntW'(1);
    else if (do_rem) count_d = count_q - CntW'(1);
  end

  // Control state: entry count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
    end else if (cmd_i.exec) begin
      count_q <= count_d;
    end
  end

  // Payload: cells and result word
  always_ff @(posedge clk_i) begin
    if (cmd_i.exec) begin
      for (int m = 0; m < Capacity; m++) cells_q[m] <= cells_d[m];
      status_q <= status_d;
      rdval_q  <= rdval_d;
      rcount_q <= count_d;
    end
  end

  assign status_o      = status_q;
  assign read_value_o  = rdval_q;
  assign entry_count_o = rcount_q;
  assign is_empty_o    = cmd_i.hold && (rcount_q == '0);

endmodule

`default_nettype wire

// ----- design/pls_checker.sv -----
// Port-level checker for the positional list store, bound to the top level.
// Depends only on the top level's ports.
`default_nettype none

module pls_checker (
  input wire logic        clk_i,
  input wire logic        rst_ni,
  input wire logic        s_tvalid,
  input wire logic        s_tready,
  input wire logic [39:0] s_tdata,
  input wire logic [1:0]  s_tuser,
  input wire logic        m_tvalid,
  input wire logic        m_tready,
  input wire logic [39:0] m_tdata
);

  // Stalled result word stays offered
  a_hold_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_tvalid && !m_tready |=> m_tvalid) else $error("result word dropped");

  // Stalled result word keeps its bits
  a_hold_data: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_tvalid && !m_tready |=> $stable(m_tdata)) else $error("result word changed");

  // Input side opens exactly when the output slot is free or draining
  a_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_tready == (!m_tvalid || m_tready)) else $error("ready mismatch");

  // Empty flag agrees with the count, and the count never passes capacity
  a_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_tvalid |-> (m_tdata[39] == (m_tdata[38:34] == 5'd0)) && (m_tdata[38:34] <= 5'd16))
    else $error("bad count or empty flag");

  // Status is never the unused code, and a rejected word reads zero
  a_status: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_tvalid |-> (m_tdata[1:0] != 2'd3) && ((m_tdata[1:0] == 2'd0) || (m_tdata[33:2] == 32'd0)))
    else $error("bad status or read value");

endmodule

bind positional_list_store pls_checker u_pls_checker (.*);

`default_nettype wire

// ----- tb/testbench.sv -----
// Self-checking testbench for positional_list_store: drives list operations over the
// input stream, predicts each result word in a small scoreboard class and checks it.
// Depends on pls_pkg and the positional_list_store RTL.

module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import pls_pkg::*;

  localparam int RandomWords = 1420;
  localparam int CycleLimit  = 400000;
  localparam int LongHoldOff = 300;

  // Expected result word, one per accepted input word
  typedef struct {
    status_e         status;
    logic [ValW-1:0] read_value;
    logic [CntW-1:0] entry_count;
    logic            is_empty;
  } list_result_t;

  // Shadow copy of the list; predicts the result of each accepted operation
  class list_tracker;
    logic [ValW-1:0] cells[Capacity];
    int              used;
    int              errors;
    list_result_t    expected_results[$];

    function new();
      used   = 0;
      errors = 0;
    endfunction

    function int pending_count();
      return expected_results.size();
    endfunction

    // Apply one accepted operation and queue the result it must produce
    function void note_op(kind_e kind, logic [CntW-1:0] pos, logic [ValW-1:0] val);
      list_result_t r;
      int           p;
      r.status     = STAT_DONE;
      r.read_value = '0;
      p            = int'(pos);
      case (kind)
        KIND_INSERT, KIND_APPEND: begin
          if (kind == KIND_APPEND) p = used;
          // full check wins over the position check
          if (used >= Capacity) r.status = STAT_FULL;
          else if (p > used) r.status = STAT_RANGE;
          else begin
            for (int m = used; m > p; m--) cells[m] = cells[m-1];
            cells[p] = val;
            used++;
          end
        end
        KIND_REMOVE: begin
          if (p >= used) r.status = STAT_RANGE;
          else begin
            for (int m = p; m + 1 < used; m++) cells[m] = cells[m+1];
            used--;
          end
        end
        default: begin
          if (p < used) r.read_value = cells[p];
          else r.status = STAT_RANGE;
        end
      endcase
      r.entry_count = CntW'(used);
      r.is_empty    = (used == 0);
      expected_results.push_back(r);
    endfunction

    function void report(string field, longint unsigned exp_v, longint unsigned act_v);
      errors++;
      if (errors <= 100) $error("%s: expected 0x%0h, got 0x%0h", field, exp_v, act_v);
    endfunction

    // Compare one output word with the oldest expectation
    function void check_word(logic [39:0] w);
      list_result_t r;
      if (expected_results.size() == 0) begin
        errors++;
        if (errors <= 100) $error("result word 0x%0h with no expectation", w);
        return;
      end
      r = expected_results.pop_front();
      if (w[1:0] !== r.status) report("status", r.status, w[1:0]);
      if (w[33:2] !== r.read_value) report("read_value", r.read_value, w[33:2]);
      if (w[38:34] !== r.entry_count) report("entry_count", r.entry_count, w[38:34]);
      if (w[39] !== r.is_empty) report("is_empty", r.is_empty, w[39]);
    endfunction
  endclass

  logic        clk_i    = 1'b0;
  logic        rst_ni   = 1'b0;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [39:0] s_tdata  = '0;   // position[4:0], item_value[36:5], zero pad
  logic [1:0]  s_tuser  = '0;   // kind[1:0]
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [39:0] m_tdata;         // status[1:0], read_value[33:2], entry_count[38:34],
                                // is_empty[39]

  list_tracker sb = new();
  bit          hold_off = 1'b0;  // receiver long stall request
  bit          steady   = 1'b0;  // sender runs without gaps
  int          cycles   = 0;

  positional_list_store dut (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

  always #5 clk_i = ~clk_i;

  // Watchdog
  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CycleLimit) begin
      $display("*** FAILED ***");
      $finish;
    end
  end

  // Accepted input words feed the predictor
  always @(posedge clk_i) begin
    if (rst_ni && s_tvalid && s_tready)
      sb.note_op(kind_e'(s_tuser), s_tdata[4:0], s_tdata[36:5]);
  end

  // Accepted output words are checked
  always @(posedge clk_i) begin
    if (rst_ni && m_tvalid && m_tready) sb.check_word(m_tdata);
  end

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic logic [ValW-1:0] pick_value();
    case ($urandom_range(0, 9))
      0: return 32'h8000_0000;
      1: return 32'h7FFF_FFFF;
      2: return 32'h0000_0000;
      3: return 32'hFFFF_FFFF;
      4: return ValW'($urandom_range(0, 15));
      default: return $urandom();
    endcase
  endfunction

  // Offer one word and wait until it is taken
  task automatic send_word(kind_e kind, logic [CntW-1:0] pos, logic [ValW-1:0] val);
    s_tvalid <= 1'b1;
    s_tuser  <= kind;
    s_tdata  <= {3'b000, val, pos};
    do @(posedge clk_i); while (!s_tready);
  endtask

  // Random gap after a word, none while the sender runs steady or the receiver is held off
  task automatic sender_gap();
    int gap;
    gap = (steady || hold_off) ? 0 : pick_gap();
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
  endtask

  task automatic put(kind_e kind, logic [CntW-1:0] pos, logic [ValW-1:0] val);
    send_word(kind, pos, val);
    sender_gap();
  endtask

  // Receiver: ready runs, short and occasional long stalls, one long hold-off
  initial begin
    int run;
    int gap;
    wait (rst_ni);
    @(posedge clk_i);
    forever begin
      if (hold_off) begin
        m_tready <= 1'b0;
        repeat (LongHoldOff) @(posedge clk_i);
        hold_off = 1'b0;
      end
      run = ($urandom_range(0, 9) == 0) ? $urandom_range(40, 120) : $urandom_range(1, 12);
      m_tready <= 1'b1;
      repeat (run) @(posedge clk_i);
      gap = pick_gap();
      if (gap > 0) begin
        m_tready <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
    end
  end

  // Stimulus
  initial begin
    int          bias;
    int          r;
    kind_e       kind;
    logic [4:0]  pos;

    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Empty list: every position out of range
    put(KIND_RETRIEVE, 5'd0, 32'h0);
    put(KIND_REMOVE, 5'd0, 32'h0);
    put(KIND_INSERT, 5'd1, 32'h1234_5678);
    // First entries, value extremes, insert in the middle
    put(KIND_INSERT, 5'd0, 32'h8000_0000);
    put(KIND_APPEND, 5'd31, 32'h7FFF_FFFF);
    put(KIND_INSERT, 5'd1, 32'hFFFF_FFFF);
    put(KIND_RETRIEVE, 5'd0, 32'h0);
    put(KIND_RETRIEVE, 5'd1, 32'h0);
    put(KIND_RETRIEVE, 5'd2, 32'h0);
    // Fill to capacity
    for (int i = 3; i < Capacity; i++) put(KIND_APPEND, 5'd0, 32'hA5A5_0000 + i);
    // Full list: full reported before range
    put(KIND_APPEND, 5'd0, 32'h1);
    put(KIND_INSERT, 5'd31, 32'h2);
    put(KIND_INSERT, 5'd0, 32'h3);
    put(KIND_RETRIEVE, 5'd15, 32'h0);
    put(KIND_RETRIEVE, 5'd16, 32'h0);
    put(KIND_REMOVE, 5'd16, 32'h0);
    put(KIND_REMOVE, 5'd15, 32'h0);
    // Insert at position equal to count acts as append
    put(KIND_INSERT, 5'd15, 32'h5A5A_5A5A);
    put(KIND_REMOVE, 5'd0, 32'h0);
    put(KIND_RETRIEVE, 5'd31, 32'h0);

    // Random part: chunks that drain, fill or hover
    bias = 2;
    for (int n = 0; n < RandomWords; n++) begin
      if (n % 60 == 0) begin
        bias   = $urandom_range(0, 2);
        steady = ($urandom_range(0, 4) == 0);
      end
      if (n == 300) hold_off = 1'b1;
      if (n == 700) begin
        // let the pipeline run dry before continuing; advance the clock first so the
        // last accepted word is already in the scoreboard
        s_tvalid <= 1'b0;
        @(posedge clk_i);
        while (sb.pending_count() != 0) @(posedge clk_i);
      end

      r = $urandom_range(0, 99);
      if (r < 10) begin
        // noise: any kind, any position
        kind = kind_e'($urandom_range(0, 3));
        pos  = 5'($urandom_range(0, 31));
      end else begin
        r = $urandom_range(0, 99);
        case (bias)
          0:       kind = (r < 15) ? KIND_INSERT : (r < 25) ? KIND_APPEND :
                          (r < 70) ? KIND_REMOVE : KIND_RETRIEVE;
          1:       kind = (r < 40) ? KIND_INSERT : (r < 70) ? KIND_APPEND :
                          (r < 85) ? KIND_REMOVE : KIND_RETRIEVE;
          default: kind = (r < 25) ? KIND_INSERT : (r < 45) ? KIND_APPEND :
                          (r < 70) ? KIND_REMOVE : KIND_RETRIEVE;
        endcase
        if (kind == KIND_INSERT) pos = 5'($urandom_range(0, sb.used));
        else if (kind == KIND_APPEND) pos = 5'($urandom_range(0, 31));
        else if (sb.used > 0) pos = 5'($urandom_range(0, sb.used - 1));
        else pos = 5'($urandom_range(0, 31));
      end
      put(kind, pos, pick_value());
    end
    s_tvalid <= 1'b0;

    // Drain and settle
    @(posedge clk_i);
    while (sb.pending_count() != 0) @(posedge clk_i);
    repeat (5) @(posedge clk_i);
    if (sb.errors == 0 && sb.pending_count() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

// ----- filelist.f -----
design/pls_pkg.sv
design/pls_ctrl.sv
design/pls_datapath.sv
design/positional_list_store.sv
design/pls_checker.sv
tb/testbench.sv
